FILE: src/ttw_pkg.sv
// Shared types and constants of the twiddled texture writer.
`default_nettype none
package ttw_pkg;

	// Widths fixed by the register and stream formats
	localparam int ADDR_W       = 24;
	localparam int TEXEL_W      = 8;
	localparam int DATA_W       = 16;
	localparam int SIZE_W       = 4;
	localparam int BITS_W       = 6;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 24;

	// Defaults and limits
	localparam int MAX_EDGE_DEF = 1024;
	localparam int Q_DEPTH      = 4;

	localparam logic [SIZE_W-1:0] SIZE_MIN     = 4'd3;
	localparam logic [SIZE_W-1:0] SIZE_RESET   = 4'd3;
	localparam logic [BITS_W-1:0] TEXEL_BITS_8 = 6'd8;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BASE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BITS = 2'd2;

	// What the back end does with a queued request
	typedef enum logic [1:0] {
		OP_STORE,
		OP_WRITE,
		OP_ERROR
	} ttw_op_t;

	typedef struct packed {
		ttw_op_t op;
		logic    last;
	} ttw_ctl_t;

endpackage
`default_nettype wire

FILE: src/ttw_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module ttw_ram #(
	parameter int Width = 8,
	parameter int Depth = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output      logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: src/ttw_queue.sv
// Short FIFO between front end and back end.
`default_nettype none
module ttw_queue #(
	parameter int Width = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [Width-1:0] din,
	input  wire logic             pop,
	output      logic [Width-1:0] dout,
	output      logic             full,
	output      logic             empty
);
	import ttw_pkg::*;

	localparam int QAW = $clog2(Q_DEPTH);

	logic [Width-1:0] slot_q [Q_DEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QAW:0]     count_q;

	assign full  = (count_q == (QAW+1)'(Q_DEPTH));
	assign empty = (count_q == '0);
	assign dout  = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: src/ttw_front.sv
// Front end: config registers, texel position counters, Morton address.
`default_nettype none
module ttw_front #(
	parameter int MaxEdge = ttw_pkg::MAX_EDGE_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [ttw_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [ttw_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  wire logic                                 in_valid,
	input  wire logic                                 room,
	input  wire logic [ttw_pkg::TEXEL_W-1:0]          texel,
	output      logic                                 push,
	output      ttw_pkg::ttw_ctl_t                    ctl,
	output      logic [$clog2(MaxEdge+1)-2:0]         col_out,
	output      logic [ttw_pkg::TEXEL_W-1:0]          texel_out,
	output      logic [ttw_pkg::ADDR_W-1:0]           addr_out
);
	import ttw_pkg::*;

	// counter width: largest supported edge is a power of two within MaxEdge
	localparam int CW = $clog2(MaxEdge+1) - 1;
	localparam int MW = 2 * CW;
	localparam logic [CW-1:0] ONES = {CW{1'b1}};

	logic [ADDR_W-1:0] base_q;
	logic [SIZE_W-1:0] size_log2_q;
	logic [BITS_W-1:0] texel_bits_q;
	logic [CW-1:0]     column_q;
	logic [CW-1:0]     row_q;

	logic          cfg_ok;
	logic [CW-1:0] mask;
	logic [CW-1:0] col;
	logic [CW-1:0] row;
	logic          col_end;
	logic          row_end;
	logic [MW-1:0] morton;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q       <= '0;
			size_log2_q  <= SIZE_RESET;
			texel_bits_q <= TEXEL_BITS_8;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BASE: base_q       <= cfg_data[ADDR_W-1:0];
				REG_SIZE: size_log2_q  <= cfg_data[SIZE_W-1:0];
				REG_BITS: texel_bits_q <= cfg_data[BITS_W-1:0];
				default:  ;
			endcase
		end
	end

	// classify and position
	assign cfg_ok  = (size_log2_q >= SIZE_MIN) && (size_log2_q <= SIZE_W'(CW)) &&
	                 (texel_bits_q == TEXEL_BITS_8);
	assign mask    = ~(ONES << size_log2_q);
	assign col     = column_q & mask;
	assign row     = row_q & mask;
	assign col_end = (col == mask);
	assign row_end = (row == mask);
	assign push    = in_valid && room;

	// Morton index: column on even bits, row pair on odd bits
	always_comb begin
		morton = '0;
		for (int i = 0; i < CW; i++) begin
			morton[2*i] = col[i];
		end
		for (int i = 0; i < CW-1; i++) begin
			morton[2*i+1] = row[i+1];
		end
	end

	// queue request
	always_comb begin
		ctl       = '{op: OP_ERROR, last: 1'b0};
		col_out   = '0;
		texel_out = '0;
		addr_out  = '0;
		if (cfg_ok) begin
			col_out   = col;
			texel_out = texel;
			addr_out  = base_q + ADDR_W'({morton, 1'b0});
			ctl.op    = row[0] ? OP_WRITE : OP_STORE;
			ctl.last  = row[0] && row_end && col_end;
		end
	end

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q    <= '0;
		end else if (push && cfg_ok) begin
			if (col_end) begin
				column_q <= '0;
				row_q    <= row_end ? '0 : row + 1'b1;
			end else begin
				column_q <= col + 1'b1;
				row_q    <= row;
			end
		end
	end

`ifndef ASSERT_OFF
	a_last_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		push && ctl.op == OP_WRITE && ctl.last |=> column_q == '0 && row_q == '0)
		else $error("counters not cleared after final write");

	a_error_holds: assert property (@(posedge clk) disable iff (!arst_n)
		push && ctl.op == OP_ERROR |=> $stable(column_q) && $stable(row_q))
		else $error("counters moved on unsupported config");

	a_addr_parity: assert property (@(posedge clk) disable iff (!arst_n)
		push && ctl.op == OP_WRITE |-> addr_out[0] == base_q[0])
		else $error("write address not word aligned to base");
`endif

endmodule
`default_nettype wire

FILE: src/ttw_back.sv
// Back end: row store access, result pairing and output register.
`default_nettype none
module ttw_back #(
	parameter int MaxEdge = ttw_pkg::MAX_EDGE_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             head_valid,
	input  wire ttw_pkg::ttw_ctl_t                head_ctl,
	input  wire logic [$clog2(MaxEdge+1)-2:0]     head_col,
	input  wire logic [ttw_pkg::TEXEL_W-1:0]      head_texel,
	input  wire logic [ttw_pkg::ADDR_W-1:0]       head_addr,
	output      logic                             pop,
	output      logic                             out_valid,
	input  wire logic                             out_ready,
	output      logic [ttw_pkg::ADDR_W-1:0]       out_addr,
	output      logic [ttw_pkg::DATA_W-1:0]       out_data,
	output      logic                             out_err,
	output      logic                             out_last
);
	import ttw_pkg::*;

	localparam int CW = $clog2(MaxEdge+1) - 1;

	logic               valid_s2;
	logic [ADDR_W-1:0]  addr_s2;
	logic [TEXEL_W-1:0] hi_s2;
	logic               err_s2;
	logic               last_s2;

	logic               out_valid_q;
	logic [ADDR_W-1:0]  out_addr_q;
	logic [DATA_W-1:0]  out_data_q;
	logic               out_err_q;
	logic               out_last_q;

	logic               out_load;
	logic               s2_free;
	logic               is_store;
	logic [TEXEL_W-1:0] lo_byte;

	// handshake between stages
	assign out_load = !out_valid_q || out_ready;
	assign s2_free  = !valid_s2 || out_load;
	assign is_store = (head_ctl.op == OP_STORE);
	assign pop      = head_valid && (is_store || s2_free);

	// row store: even rows write, odd rows read
	ttw_ram #(
		.Width (TEXEL_W),
		.Depth (1 << CW)
	) u_row_store (
		.clk   (clk),
		.we    (pop && is_store),
		.waddr (head_col),
		.wdata (head_texel),
		.re    (pop && head_ctl.op == OP_WRITE),
		.raddr (head_col),
		.rdata (lo_byte)
	);

	// stage 2: waiting for row store data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= pop && !is_store;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && pop && !is_store) begin
			addr_s2 <= head_addr;
			hi_s2   <= head_texel;
			err_s2  <= (head_ctl.op == OP_ERROR);
			last_s2 <= head_ctl.last;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && valid_s2) begin
			out_addr_q <= addr_s2;
			out_data_q <= err_s2 ? '0 : {hi_s2, lo_byte};
			out_err_q  <= err_s2;
			out_last_q <= last_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign out_addr  = out_addr_q;
	assign out_data  = out_data_q;
	assign out_err   = out_err_q;
	assign out_last  = out_last_q;

`ifndef ASSERT_OFF
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_err_q |-> out_addr_q == '0 && out_data_q == '0 && !out_last_q)
		else $error("error result carries a payload");

	a_read_lands: assert property (@(posedge clk) disable iff (!arst_n)
		pop && head_ctl.op == OP_WRITE |=> valid_s2)
		else $error("row store read lost its stage");
`endif

endmodule
`default_nettype wire

FILE: src/twiddled_texture_writer.sv
// Path: an odd-row texel's write passes the request queue, stage 2 and the output register.
// Throughput: one texel per cycle while the queue is not full; the 4-entry request queue
// and the output register let input and output stall independently.
// Even-row texels produce no output; bad config gives one error result per texel.
// Reset: counters cleared, registers to base 0 / size_log2 3 / 8 bits, queue
// and output empty; the row store is not cleared.
`default_nettype none
module twiddled_texture_writer #(
	parameter int MaxEdge = ttw_pkg::MAX_EDGE_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [ttw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [ttw_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                             s_tvalid,
	output      logic                             s_tready,
	input  wire logic [7:0]                       s_tdata,  // [7:0] texel
	output      logic                             m_tvalid,
	input  wire logic                             m_tready,
	output      logic [39:0]                      m_tdata,  // [23:0] write_address, [39:24] write_data
	output      logic                             m_tuser,  // [0] error
	output      logic                             m_tlast
);
	import ttw_pkg::*;

	localparam int CW = $clog2(MaxEdge+1) - 1;
	localparam int EW = $bits(ttw_ctl_t) + CW + TEXEL_W + ADDR_W;

	logic               q_full;
	logic               q_empty;
	logic               push;
	logic               pop;
	ttw_ctl_t           f_ctl;
	logic [CW-1:0]      f_col;
	logic [TEXEL_W-1:0] f_texel;
	logic [ADDR_W-1:0]  f_addr;
	logic [EW-1:0]      q_in;
	logic [EW-1:0]      q_out;
	ttw_ctl_t           b_ctl;
	logic [CW-1:0]      b_col;
	logic [TEXEL_W-1:0] b_texel;
	logic [ADDR_W-1:0]  b_addr;
	logic [ADDR_W-1:0]  o_addr;
	logic [DATA_W-1:0]  o_data;

	assign s_tready = !q_full;

	ttw_front #(
		.MaxEdge (MaxEdge)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_tvalid),
		.room      (!q_full),
		.texel     (s_tdata),
		.push      (push),
		.ctl       (f_ctl),
		.col_out   (f_col),
		.texel_out (f_texel),
		.addr_out  (f_addr)
	);

	// request queue
	assign q_in = {f_ctl, f_col, f_texel, f_addr};

	ttw_queue #(
		.Width (EW)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (q_in),
		.pop    (pop),
		.dout   (q_out),
		.full   (q_full),
		.empty  (q_empty)
	);

	assign {b_ctl, b_col, b_texel, b_addr} = q_out;

	ttw_back #(
		.MaxEdge (MaxEdge)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (!q_empty),
		.head_ctl   (b_ctl),
		.head_col   (b_col),
		.head_texel (b_texel),
		.head_addr  (b_addr),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_addr   (o_addr),
		.out_data   (o_data),
		.out_err    (m_tuser),
		.out_last   (m_tlast)
	);

	assign m_tdata = {o_data, o_addr};

endmodule
`default_nettype wire
